// ----- rtl/spms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spms_pkg: shared definitions for the shared-pool multi-stack
// Operation and status codes, back-end states, the classified command
// control word and the default sizes used by the top level.
// ----------------------------------------------------------------------------
package spms_pkg;

	localparam int unsigned NUM_STACKS_DEF = 4;
	localparam int unsigned POOL_DEPTH_DEF = 256;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// width of the value ports
	localparam int unsigned VALUE_W = 32;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	localparam int unsigned STATUS_W = $bits(status_t);

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FETCH,
		BK_POP_DONE
	} back_state_t;

	// control part of a classified command
	typedef struct packed {
		logic is_pop;
		logic sid_ok;
	} op_ctl_t;

	localparam int unsigned CTL_W = $bits(op_ctl_t);

	// data returned by a pop of an empty stack
	localparam logic [VALUE_W-1:0] UNDERFLOW_DATA = '1;

endpackage
`default_nettype wire

// ----- rtl/spms_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spms_fifo: two-entry register queue
// Holds beats between the front and back, and results for the consumer.
// Ignores a write while full, even when a read happens in the same cycle.
// ----------------------------------------------------------------------------
module spms_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);
	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_go;
	logic             rd_go;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_go   = wr_en && !full;
	assign rd_go   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_go) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_go) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_go && !rd_go) begin
				count_q <= count_q + 1'b1;
			end else if (rd_go && !wr_go) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store the incoming beat
	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fifo occupancy beyond depth");
	a_write_only_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_go && !rd_go) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fifo lost a written beat");
	a_read_only_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_go && !wr_go) |=> (count_q == $past(count_q) - 1'b1))
		else $error("fifo repeated a beat");
`endif

endmodule
`default_nettype wire

// ----- rtl/spms_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spms_front: command intake
// Accepts push/pop beats, classifies the operation and the stack id, and
// queues the classified command for the back end.
// ----------------------------------------------------------------------------
module spms_front #(
	parameter int unsigned NUM_STACKS = 4,
	parameter int unsigned SID_W      = 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          op,
	input  wire logic [SID_W-1:0]              stack_id,
	input  wire logic [spms_pkg::VALUE_W-1:0]  push_value,
	output logic                               cmd_valid,
	input  wire logic                          cmd_take,
	output spms_pkg::op_ctl_t                  cmd_ctl,
	output logic      [SID_W-1:0]              cmd_sid,
	output logic      [spms_pkg::VALUE_W-1:0]  cmd_value
);
	import spms_pkg::*;

	localparam int unsigned CMD_W = CTL_W + SID_W + VALUE_W;

	op_ctl_t          in_ctl;
	logic [CMD_W-1:0] wr_data;
	logic [CMD_W-1:0] rd_data;
	logic             q_empty;

	// classify the operation and range-check the stack id
	always_comb begin
		in_ctl.is_pop = (op == OP_POP);
		in_ctl.sid_ok = ({1'b0, stack_id} < (SID_W + 1)'(NUM_STACKS));
	end

	assign wr_data = {in_ctl, stack_id, push_value};

	spms_fifo #(
		.WIDTH (CMD_W)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (wr_data),
		.full    (full),
		.rd_en   (cmd_take),
		.rd_data (rd_data),
		.empty   (q_empty)
	);

	assign cmd_valid = !q_empty;
	assign cmd_ctl   = op_ctl_t'(rd_data[CMD_W-1 -: CTL_W]);
	assign cmd_sid   = rd_data[VALUE_W +: SID_W];
	assign cmd_value = rd_data[VALUE_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/spms_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spms_back: stack engine
// Owns the value and link memories, the stack head pointers and the free
// list. Runs one command at a time: push via IDLE, FETCH; pop also POP_DONE.
// Entries never allocated are tracked by a fill count instead of a sweep.
// ----------------------------------------------------------------------------
module spms_back #(
	parameter int unsigned NUM_STACKS = 4,
	parameter int unsigned POOL_DEPTH = 256,
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned SID_W      = 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_take,
	input  wire spms_pkg::op_ctl_t             cmd_ctl,
	input  wire logic [SID_W-1:0]              cmd_sid,
	input  wire logic [spms_pkg::VALUE_W-1:0]  cmd_value,
	input  wire logic                          res_full,
	output logic                               res_push,
	output logic      [spms_pkg::VALUE_W-1:0]  res_data,
	output spms_pkg::status_t                  res_status
);
	import spms_pkg::*;

	localparam int unsigned PTR_W  = $clog2(POOL_DEPTH + 1);
	localparam int unsigned ADDR_W = $clog2(POOL_DEPTH);
	localparam logic [PTR_W-1:0] NIL  = PTR_W'(POOL_DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(POOL_DEPTH - 1);

	// storage
	logic [DATA_WIDTH-1:0] value_mem [POOL_DEPTH];
	logic [PTR_W-1:0]      link_mem  [POOL_DEPTH];
	logic [PTR_W-1:0]      head_mem  [NUM_STACKS];
	logic [NUM_STACKS-1:0] head_vld_q;

	// control
	back_state_t state_q;
	back_state_t state_d;
	logic [PTR_W-1:0] free_head_q;
	logic [PTR_W-1:0] fill_q;

	// current command and read data
	logic                  sid_ok_q;
	logic                  is_pop_q;
	logic [SID_W-1:0]      sid_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [PTR_W-1:0]      entry_q;
	logic [PTR_W-1:0]      head_rd_q;
	logic [PTR_W-1:0]      link_rd_q;
	logic [DATA_WIDTH-1:0] value_rd_q;

	logic             take;
	logic             push_commit;
	logic             pop_fetch;
	logic             pop_commit;
	logic             fresh;
	logic [PTR_W-1:0] head_cur;
	logic [PTR_W-1:0] fill_next;
	logic [PTR_W-1:0] free_next;
	logic [ADDR_W-1:0] link_raddr;

	assign take     = (state_q == BK_IDLE) && cmd_valid && !res_full;
	assign cmd_take = take;

	// a stack never written reads as empty
	assign head_cur  = head_vld_q[sid_q] ? head_rd_q : NIL;
	// the free list ends in the run of never-used entries starting at fill_q
	assign fresh     = (free_head_q == fill_q);
	assign fill_next = (fill_q == LAST) ? NIL : fill_q + 1'b1;
	assign free_next = fresh ? fill_next : link_rd_q;

	assign link_raddr = pop_fetch ? head_cur[ADDR_W-1:0] : free_head_q[ADDR_W-1:0];

	// sequence one command and produce its result
	always_comb begin
		state_d     = state_q;
		res_push    = 1'b0;
		res_data    = '0;
		res_status  = ST_OK;
		push_commit = 1'b0;
		pop_fetch   = 1'b0;
		pop_commit  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (take) begin
					state_d = BK_FETCH;
				end
			end
			BK_FETCH: begin
				if (!is_pop_q) begin
					res_push = 1'b1;
					state_d  = BK_IDLE;
					if (!sid_ok_q || free_head_q == NIL) begin
						res_status = ST_OVERFLOW;
					end else begin
						push_commit = 1'b1;
					end
				end else if (!sid_ok_q || head_cur == NIL) begin
					res_push   = 1'b1;
					res_status = ST_UNDERFLOW;
					res_data   = UNDERFLOW_DATA;
					state_d    = BK_IDLE;
				end else begin
					pop_fetch = 1'b1;
					state_d   = BK_POP_DONE;
				end
			end
			BK_POP_DONE: begin
				res_push   = 1'b1;
				res_data   = VALUE_W'($signed(value_rd_q));
				pop_commit = 1'b1;
				state_d    = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// hold state, free list head, fill count and head valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			free_head_q <= '0;
			fill_q      <= '0;
			head_vld_q  <= '0;
		end else begin
			state_q <= state_d;
			if (push_commit) begin
				free_head_q <= free_next;
				if (fresh) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (pop_commit) begin
				free_head_q <= entry_q;
			end
			if (push_commit || pop_commit) begin
				head_vld_q[sid_q] <= 1'b1;
			end
		end
	end

	// latch the command and the entry being popped
	always_ff @(posedge clk) begin
		if (take) begin
			is_pop_q <= cmd_ctl.is_pop;
			sid_ok_q <= cmd_ctl.sid_ok;
			sid_q    <= cmd_sid;
			value_q  <= DATA_WIDTH'(cmd_value);
		end
		if (pop_fetch) begin
			entry_q <= head_cur;
		end
	end

	// head pointer memory
	always_ff @(posedge clk) begin
		if (take) begin
			head_rd_q <= head_mem[cmd_sid];
		end
		if (push_commit) begin
			head_mem[sid_q] <= free_head_q;
		end else if (pop_commit) begin
			head_mem[sid_q] <= link_rd_q;
		end
	end

	// link memory
	always_ff @(posedge clk) begin
		if (take || pop_fetch) begin
			link_rd_q <= link_mem[link_raddr];
		end
		if (push_commit) begin
			link_mem[free_head_q[ADDR_W-1:0]] <= head_cur;
		end else if (pop_commit) begin
			link_mem[entry_q[ADDR_W-1:0]] <= free_head_q;
		end
	end

	// value memory
	always_ff @(posedge clk) begin
		if (pop_fetch) begin
			value_rd_q <= value_mem[head_cur[ADDR_W-1:0]];
		end
		if (push_commit) begin
			value_mem[free_head_q[ADDR_W-1:0]] <= value_q;
		end
	end

`ifndef SYNTHESIS
	a_free_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q <= fill_q) || (free_head_q == NIL))
		else $error("free list head points past the used region");
	a_result_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result produced with no room in the result queue");
	a_pop_done_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_POP_DONE) |-> ($past(state_q) == BK_FETCH))
		else $error("pop completion without a fetch");
`endif

endmodule
`default_nettype wire

// ----- rtl/shared_pool_multi_stack.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shared_pool_multi_stack: several LIFO stacks sharing one entry pool
// A front end queues push/pop commands; a back end runs them against a
// linked free list, per-stack head pointers and a value/link memory.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   command  | in        | push / full        | op, stack_id, push_value
//   result   | out       | empty / pop        | pop_data, status
//
// The back end steps a push through IDLE and FETCH and a pop on to POP_DONE,
// set by the dependent registered reads of head, then link and value memory.
// Each command yields exactly one result, in command order.
// Reset empties all stacks at once; no clearing pass is needed.
// Two command beats and two result beats can be held while either side stalls.
// ----------------------------------------------------------------------------
module shared_pool_multi_stack #(
	parameter int unsigned NUM_STACKS = spms_pkg::NUM_STACKS_DEF,
	parameter int unsigned POOL_DEPTH = spms_pkg::POOL_DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = spms_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic                             op,
	input  wire logic [$clog2(NUM_STACKS)-1:0]    stack_id,
	input  wire logic [spms_pkg::VALUE_W-1:0]     push_value,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic      [spms_pkg::VALUE_W-1:0]     pop_data,
	output logic      [spms_pkg::STATUS_W-1:0]    status
);
	import spms_pkg::*;

	localparam int unsigned SID_W = $clog2(NUM_STACKS);
	localparam int unsigned RES_W = VALUE_W + STATUS_W;

	logic                 cmd_valid;
	logic                 cmd_take;
	op_ctl_t              cmd_ctl;
	logic [SID_W-1:0]     cmd_sid;
	logic [VALUE_W-1:0]   cmd_value;
	logic                 res_full;
	logic                 res_push;
	logic [VALUE_W-1:0]   res_data;
	status_t              res_status;
	logic [RES_W-1:0]     res_rd;

	spms_front #(
		.NUM_STACKS (NUM_STACKS),
		.SID_W      (SID_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.stack_id   (stack_id),
		.push_value (push_value),
		.cmd_valid  (cmd_valid),
		.cmd_take   (cmd_take),
		.cmd_ctl    (cmd_ctl),
		.cmd_sid    (cmd_sid),
		.cmd_value  (cmd_value)
	);

	spms_back #(
		.NUM_STACKS (NUM_STACKS),
		.POOL_DEPTH (POOL_DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.SID_W      (SID_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_take   (cmd_take),
		.cmd_ctl    (cmd_ctl),
		.cmd_sid    (cmd_sid),
		.cmd_value  (cmd_value),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_data),
		.res_status (res_status)
	);

	// result queue toward the consumer
	spms_fifo #(
		.WIDTH (RES_W)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data ({res_data, res_status}),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_rd),
		.empty   (empty)
	);

	assign pop_data = res_rd[RES_W-1 -: VALUE_W];
	assign status   = res_rd[STATUS_W-1:0];

endmodule
`default_nettype wire
